>>> rtl/i2cm_pkg.sv
// Shared types and codes for the I2C master bit sequencer.
package i2cm_pkg;

  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_STOP    = 3'd1,
    OP_TX_BYTE = 3'd2,
    OP_RX_BYTE = 3'd3,
    OP_TX_ACK  = 3'd4,
    OP_RX_ACK  = 3'd5
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic [7:0] bus_sample;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  localparam int unsigned QueueDepth = 2;

endpackage

>>> rtl/i2cm_front.sv
// Front stage: accepts bus commands, drops unused codes and feeds the command queue.
module i2cm_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              operation,
  input  logic [7:0]              tx_byte,
  input  logic                    ack_level,
  input  logic [7:0]              bus_sample,
  input  i2cm_pkg::queue_status_t q_status,
  output logic                    push,
  output i2cm_pkg::cmd_t          push_cmd
);
  import i2cm_pkg::*;

  logic front_valid;
  cmd_t front_cmd;
  logic accept;
  logic known_op;

  assign in_stall = front_valid && q_status.full;
  assign push     = front_valid && !q_status.full;
  assign push_cmd = front_cmd;
  assign accept   = in_valid && !in_stall;
  // Codes past the last operation produce nothing and are dropped here.
  assign known_op = (operation <= 3'(OP_RX_ACK));

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (accept) begin
      front_valid <= known_op;
    end else if (push) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_cmd.op         <= op_t'(operation);
      front_cmd.tx_byte    <= tx_byte;
      front_cmd.ack_level  <= ack_level;
      front_cmd.bus_sample <= bus_sample;
    end
  end

endmodule

>>> rtl/i2cm_cmd_queue.sv
// Two-entry command queue between the front stage and the phase sequencer.
module i2cm_cmd_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  i2cm_pkg::cmd_t          push_cmd,
  input  logic                    pop,
  output i2cm_pkg::cmd_t          head,
  output i2cm_pkg::queue_status_t status
);
  import i2cm_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  cmd_t            entries [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;

  assign head         = entries[rd_ptr];
  assign status.full  = (count == (PtrW+1)'(QueueDepth));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

>>> rtl/i2cm_back.sv
// Back stage: runs one command's pin phases, one a cycle unless the output stalls.
module i2cm_back (
  input  logic                    clk,
  input  logic                    rst,
  input  i2cm_pkg::cmd_t          head,
  input  i2cm_pkg::queue_status_t q_status,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    scl_level,
  output logic                    sda_level,
  output logic                    run_last,
  output logic [7:0]              read_byte,
  output logic                    ack_received
);
  import i2cm_pkg::*;

  logic       busy;
  cmd_t       cmd;
  logic [1:0] step;
  logic [2:0] bit_idx;
  logic       clock_line;
  logic       data_line;

  logic       out_free;
  logic       advance;
  logic       scl_next;
  logic       sda_next;
  logic       last_next;
  logic [7:0] rb_next;
  logic       ack_next;
  logic [1:0] step_next;
  logic [2:0] bit_next;

  assign out_free = !out_valid || !out_stall;
  assign advance  = busy && out_free;
  assign pop      = !q_status.empty && (!busy || (advance && last_next));

  always_comb begin
    scl_next  = clock_line;
    sda_next  = data_line;
    last_next = 1'b0;
    rb_next   = '0;
    ack_next  = 1'b0;
    step_next = step + 2'd1;
    bit_next  = bit_idx;
    case (cmd.op)
      OP_START: begin
        case (step)
          2'd0:    sda_next = 1'b1;
          2'd1:    scl_next = 1'b1;
          2'd2:    sda_next = 1'b0;
          default: begin
            scl_next  = 1'b0;
            last_next = 1'b1;
          end
        endcase
      end
      OP_STOP: begin
        case (step)
          2'd0:    sda_next = 1'b0;
          2'd1:    scl_next = 1'b1;
          default: begin
            sda_next  = 1'b1;
            last_next = 1'b1;
          end
        endcase
      end
      OP_TX_BYTE, OP_RX_BYTE: begin
        case (step)
          2'd0: begin
            if (cmd.op == OP_TX_BYTE) begin
              sda_next = cmd.tx_byte[3'd7 - bit_idx];
            end else begin
              sda_next = 1'b1;
            end
          end
          2'd1:    scl_next = 1'b1;
          default: begin
            scl_next  = 1'b0;
            last_next = (bit_idx == 3'd7);
            bit_next  = bit_idx + 3'd1;
            // Sending redrives SDA for every bit; receiving only toggles SCL.
            step_next = (cmd.op == OP_TX_BYTE) ? 2'd0 : 2'd1;
            if (cmd.op == OP_RX_BYTE && last_next) begin
              rb_next = cmd.bus_sample;
            end
          end
        endcase
      end
      OP_TX_ACK, OP_RX_ACK: begin
        case (step)
          2'd0:    sda_next = (cmd.op == OP_TX_ACK) ? cmd.ack_level : 1'b1;
          2'd1:    scl_next = 1'b1;
          default: begin
            scl_next  = 1'b0;
            last_next = 1'b1;
            if (cmd.op == OP_RX_ACK) begin
              ack_next = cmd.bus_sample[7];
            end
          end
        endcase
      end
      default: begin
        last_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      step         <= '0;
      bit_idx      <= '0;
      clock_line   <= 1'b1;
      data_line    <= 1'b1;
      out_valid    <= 1'b0;
      scl_level    <= 1'b1;
      sda_level    <= 1'b1;
      run_last     <= 1'b0;
      read_byte    <= '0;
      ack_received <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= advance;
      end
      if (advance) begin
        clock_line   <= scl_next;
        data_line    <= sda_next;
        scl_level    <= scl_next;
        sda_level    <= sda_next;
        run_last     <= last_next;
        read_byte    <= rb_next;
        ack_received <= ack_next;
        step         <= step_next;
        bit_idx      <= bit_next;
      end
      if (pop) begin
        busy    <= 1'b1;
        step    <= '0;
        bit_idx <= '0;
      end else if (advance && last_next) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head;
    end
  end

endmodule

>>> rtl/i2c_master_bit_sequencer_unit.sv
// An accepted item passes the front register, a queue entry and the back stage's
// command register before its first pin phase. One pin phase leaves per cycle
// unless stalled; commands of 3 to 24 phases (a send byte has 24) run back to back.
// Unused operation codes are accepted and produce no phase.
// Reset (synchronous, active high) empties the queue and returns both lines to
// released high, the idle bus.
module i2c_master_bit_sequencer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] operation,
  input  logic [7:0] tx_byte,
  input  logic       ack_level,
  input  logic [7:0] bus_sample,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       scl_level,
  output logic       sda_level,
  output logic       run_last,
  output logic [7:0] read_byte,
  output logic       ack_received
);
  import i2cm_pkg::*;

  // The front stage registers each item and drops codes with no phases.
  // The queue lets the front keep taking items while a long run is in progress.
  // The back stage owns the bus line state and emits one phase per unstalled cycle
  // into its output register, which can be refilled in the same cycle it is taken.
  queue_status_t q_status;
  logic          push;
  cmd_t          push_cmd;
  logic          pop;
  cmd_t          head;

  i2cm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .tx_byte    (tx_byte),
    .ack_level  (ack_level),
    .bus_sample (bus_sample),
    .q_status   (q_status),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  i2cm_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  i2cm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .scl_level    (scl_level),
    .sda_level    (sda_level),
    .run_last     (run_last),
    .read_byte    (read_byte),
    .ack_received (ack_received)
  );

`ifndef SYNTHESIS
  // Every phase moves at most one bus line, so both levels never change together.
  assert property (@(posedge clk) disable iff (rst)
    !((scl_level != $past(scl_level)) && (sda_level != $past(sda_level))))
    else $error("both bus lines changed in one phase");

  // Received data shows only on the final phase of a command.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !run_last) |-> (read_byte == 8'd0 && ack_received == 1'b0))
    else $error("received data outside the final phase");

  // The front never writes into a full queue, and the back never reads an empty one.
  assert property (@(posedge clk) disable iff (rst)
    !(push && q_status.full) && !(pop && q_status.empty))
    else $error("command queue overflow or underflow");
`endif

endmodule
